>>> rtl/ssra_pkg.sv
// Shared types, constants and fixed-point helpers for the sparse row accumulator.
package ssra_pkg;

    // Fixed field widths
    localparam int VAL_W      = 32;
    localparam int IDX_PORT_W = 16;
    localparam int POS_W      = 6;
    localparam int CNT_OUT_W  = 7;

    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

    // Command codes
    typedef enum logic [2:0] {
        CMD_ADD_COEF  = 3'd0,
        CMD_ADD_CONST = 3'd1,
        CMD_SCALE     = 3'd2,
        CMD_CLEAR     = 3'd3,
        CMD_READ      = 3'd4
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // What the head stage does to the entry it holds
    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ACC,
        MODE_SCALE
    } mode_t;

    // Controller to head stage
    typedef struct packed {
        logic start;
        logic shift;
        logic add_coef;
        logic scale;
        logic occupied;
        logic const_slot;
        logic table_full;
    } head_ctrl_t;

    // Head stage to controller
    typedef struct packed {
        logic inserted;
        logic overflow;
        logic sat_seen;
        logic ret_clip;
    } head_stat_t;

    // Q16.16 value with clip flag
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    clipped;
    } qres_t;

    // Saturating Q16.16 add
    function automatic qres_t q_sat_add(logic signed [VAL_W-1:0] a,
                                        logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        qres_t                 r;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
        begin
            r.clipped = 1'b1;
            r.value   = s[VAL_W] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r.clipped = 1'b0;
            r.value   = s[VAL_W-1:0];
        end
        return r;
    endfunction

    // Round a full product to Q16.16 (half up) and clip
    function automatic qres_t q_round_clip(logic signed [2*VAL_W-1:0] p);
        logic signed [2*VAL_W-1:0] r;
        logic        [47:0]        q;
        qres_t                     res;
        r = p + 64'sd32768;
        q = r[63:16];
        if ((&q[47:31]) || !(|q[47:31]))
        begin
            res.clipped = 1'b0;
            res.value   = q[31:0];
        end
        else
        begin
            res.clipped = 1'b1;
            res.value   = q[47] ? Q_MIN : Q_MAX;
        end
        return res;
    endfunction

endpackage

>>> rtl/sorted_sparse_row_accumulator.sv
// Top level of the sorted sparse row accumulator: controller, entry ring, result register.
//
// Holds one sparse row as (index, Q16.16 value) pairs sorted by index in a ring of
// CAPACITY cells plus one head stage, and a constant term. Add coefficient, scale
// and read rotate the whole ring once through the head stage, one entry per cycle:
// such a command is accepted, walks the ring in CAPACITY + 1 steps, then finishes.
// Add constant, clear and the unused codes go from accept straight to finish.
// The scale multiplier in the head is one signed 32x32 product per cycle,
// registered before rounding and clipping. One result item is produced per
// command; the result register lets it wait while the next command is accepted.
// The row store is not cleared at reset: only positions below the entry count
// are ever read.
module sorted_sparse_row_accumulator #(
    parameter int CAPACITY   = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [2:0]                        command,
    input  logic [ssra_pkg::IDX_PORT_W-1:0]   entry_index,
    input  logic signed [ssra_pkg::VAL_W-1:0] operand_value,
    input  logic [ssra_pkg::POS_W-1:0]        read_position,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [ssra_pkg::IDX_PORT_W-1:0]   out_index,
    output logic signed [ssra_pkg::VAL_W-1:0] out_value,
    output logic [ssra_pkg::CNT_OUT_W-1:0]    count_now,
    output logic signed [ssra_pkg::VAL_W-1:0] constant_now,
    output logic                              overflow,
    output logic                              saturated
);

    localparam int IDX_W = (INDEX_BITS < ssra_pkg::IDX_PORT_W) ? INDEX_BITS
                                                                : ssra_pkg::IDX_PORT_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ssra_pkg::POS_W) ? CNT_W : ssra_pkg::POS_W;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CAPACITY);

    // Controller state
    ssra_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] step_reg,  step_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic signed [ssra_pkg::VAL_W-1:0] const_reg, const_next;

    // Command held for the duration of its work
    ssra_pkg::cmd_t                    cmd_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic signed [ssra_pkg::VAL_W-1:0] opv_reg;
    logic [ssra_pkg::POS_W-1:0]        pos_reg;

    // Read capture
    logic [IDX_W-1:0]                  rd_idx_reg, rd_idx_next;
    logic signed [ssra_pkg::VAL_W-1:0] rd_val_reg, rd_val_next;

    // Result register
    logic                              res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]                  res_idx_reg;
    logic signed [ssra_pkg::VAL_W-1:0] res_val_reg;
    logic [ssra_pkg::CNT_OUT_W-1:0]    res_cnt_reg;
    logic signed [ssra_pkg::VAL_W-1:0] res_const_reg;
    logic                              res_ovf_reg;
    logic                              res_sat_reg;

    // Handshake and sequencing controls
    logic accept;
    logic shift;
    logic out_free;
    logic out_load;
    logic ring_cmd;
    logic occupied;

    // Finish values
    logic [CNT_W-1:0]                  fin_cnt;
    logic signed [ssra_pkg::VAL_W-1:0] fin_const;
    logic                              fin_ovf;
    logic                              fin_sat;
    ssra_pkg::qres_t                   const_sum;

    // Ring wiring
    logic [IDX_W-1:0]                  cell_idx [CAPACITY];
    logic signed [ssra_pkg::VAL_W-1:0] cell_val [CAPACITY];
    logic [IDX_W-1:0]                  ret_index;
    logic signed [ssra_pkg::VAL_W-1:0] ret_value;
    ssra_pkg::head_ctrl_t              hctrl;
    ssra_pkg::head_stat_t              hstat;

    assign ring_cmd = (ssra_pkg::cmd_t'(command) == ssra_pkg::CMD_ADD_COEF)
                   || (ssra_pkg::cmd_t'(command) == ssra_pkg::CMD_SCALE)
                   || (ssra_pkg::cmd_t'(command) == ssra_pkg::CMD_READ);
    assign out_free = !res_valid_reg || !res_stall;
    assign occupied = step_reg < cnt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssra_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ring_cmd ? ssra_pkg::ST_RUN : ssra_pkg::ST_FINISH;
                end
            end
            ssra_pkg::ST_RUN:
            begin
                if (step_reg == LAST)
                begin
                    state_next = ssra_pkg::ST_FINISH;
                end
            end
            ssra_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ssra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssra_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_stall = 1'b1;
        accept    = 1'b0;
        shift     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ssra_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                accept    = cmd_valid;
            end
            ssra_pkg::ST_RUN:
            begin
                shift = 1'b1;
            end
            ssra_pkg::ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Step counter
    always_comb
    begin
        step_next = step_reg;
        if (accept)
        begin
            step_next = '0;
        end
        else if (shift && (step_reg != LAST))
        begin
            step_next = step_reg + CNT_W'(1);
        end
    end

    // Read capture as the requested position passes the head
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        rd_val_next = rd_val_reg;
        if (accept)
        begin
            rd_idx_next = '0;
            rd_val_next = '0;
        end
        else if (shift && (cmd_reg == ssra_pkg::CMD_READ) && occupied
                 && (CMP_W'(step_reg) == CMP_W'(pos_reg)))
        begin
            rd_idx_next = cell_idx[0];
            rd_val_next = cell_val[0];
        end
    end

    // Head stage controls
    always_comb
    begin
        hctrl.start      = accept;
        hctrl.shift      = shift;
        hctrl.add_coef   = (cmd_reg == ssra_pkg::CMD_ADD_COEF);
        hctrl.scale      = (cmd_reg == ssra_pkg::CMD_SCALE);
        hctrl.occupied   = occupied;
        hctrl.const_slot = (step_reg == LAST);
        hctrl.table_full = (cnt_reg == LAST);
    end

    // Final values of the command
    assign const_sum = ssra_pkg::q_sat_add(const_reg, opv_reg);

    always_comb
    begin
        fin_cnt   = cnt_reg;
        fin_const = const_reg;
        fin_ovf   = 1'b0;
        fin_sat   = 1'b0;
        case (cmd_reg)
            ssra_pkg::CMD_ADD_COEF:
            begin
                if (hstat.inserted)
                begin
                    fin_cnt = cnt_reg + CNT_W'(1);
                end
                fin_ovf = hstat.overflow;
                fin_sat = hstat.sat_seen | hstat.ret_clip;
            end
            ssra_pkg::CMD_ADD_CONST:
            begin
                fin_const = const_sum.value;
                fin_sat   = const_sum.clipped;
            end
            ssra_pkg::CMD_SCALE:
            begin
                fin_const = ret_value;
                fin_sat   = hstat.sat_seen | hstat.ret_clip;
            end
            ssra_pkg::CMD_CLEAR:
            begin
                fin_cnt   = '0;
                fin_const = '0;
            end
            default:
            begin
                fin_cnt = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = out_load ? fin_cnt : cnt_reg;
        const_next     = out_load ? fin_const : const_reg;
        res_valid_next = out_load ? 1'b1 : (res_valid_reg && res_stall);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssra_pkg::ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            const_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            const_reg     <= const_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= ssra_pkg::cmd_t'(command);
            idx_reg <= IDX_W'(entry_index);
            opv_reg <= operand_value;
            pos_reg <= read_position;
        end
        rd_idx_reg <= rd_idx_next;
        rd_val_reg <= rd_val_next;
        if (out_load)
        begin
            res_idx_reg   <= (cmd_reg == ssra_pkg::CMD_READ) ? rd_idx_reg : '0;
            res_val_reg   <= (cmd_reg == ssra_pkg::CMD_READ) ? rd_val_reg : '0;
            res_cnt_reg   <= ssra_pkg::CNT_OUT_W'(fin_cnt);
            res_const_reg <= fin_const;
            res_ovf_reg   <= fin_ovf;
            res_sat_reg   <= fin_sat;
        end
    end

    // Entry ring: cell 0 feeds the head, the head feeds the last cell
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [IDX_W-1:0]                  nb_idx;
        logic signed [ssra_pkg::VAL_W-1:0] nb_val;
        if (i == CAPACITY - 1)
        begin : g_tail
            assign nb_idx = ret_index;
            assign nb_val = ret_value;
        end
        else
        begin : g_mid
            assign nb_idx = cell_idx[i+1];
            assign nb_val = cell_val[i+1];
        end
        ssra_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .in_index (nb_idx),
            .in_value (nb_val),
            .index    (cell_idx[i]),
            .value    (cell_val[i])
        );
    end

    ssra_head #(
        .IDX_W (IDX_W)
    ) u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (hctrl),
        .op_index  (idx_reg),
        .op_value  (opv_reg),
        .cur_const (const_reg),
        .in_index  (cell_idx[0]),
        .in_value  (cell_val[0]),
        .ret_index (ret_index),
        .ret_value (ret_value),
        .stat      (hstat)
    );

    // Result ports
    assign res_valid    = res_valid_reg;
    assign out_index    = ssra_pkg::IDX_PORT_W'(res_idx_reg);
    assign out_value    = res_val_reg;
    assign count_now    = res_cnt_reg;
    assign constant_now = res_const_reg;
    assign overflow     = res_ovf_reg;
    assign saturated    = res_sat_reg;

`ifndef SYNTHESIS
    // Entry count never exceeds the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST)
        else $error("entry count beyond capacity");

    // A dropped insert only happens on a full table
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_ovf_reg) |-> (cnt_reg == LAST))
        else $error("overflow reported on a table with room");

    // The row count only moves when a command finishes
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ssra_pkg::ST_FINISH) |=> $stable(cnt_reg))
        else $error("entry count changed outside finish");

    // Ring walk stays within one revolution
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssra_pkg::ST_RUN) |-> (step_reg <= LAST))
        else $error("ring step past last slot");
`endif

endmodule

>>> rtl/ssra_cell.sv
// One storage cell of the entry ring: holds an index/value pair and passes it on.
module ssra_cell #(
    parameter int IDX_W = 16
) (
    input  logic                              clk,
    input  logic                              shift,
    input  logic [IDX_W-1:0]                  in_index,
    input  logic signed [ssra_pkg::VAL_W-1:0] in_value,
    output logic [IDX_W-1:0]                  index,
    output logic signed [ssra_pkg::VAL_W-1:0] value
);

    logic [IDX_W-1:0]                  index_reg;
    logic signed [ssra_pkg::VAL_W-1:0] value_reg;

    // Take the neighbor's entry on every ring step
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            index_reg <= in_index;
            value_reg <= in_value;
        end
    end

    assign index = index_reg;
    assign value = value_reg;

endmodule

>>> rtl/ssra_head.sv
// Head stage of the ring: sorted insert, accumulate, and the scale multiplier.
module ssra_head #(
    parameter int IDX_W = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssra_pkg::head_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]                  op_index,
    input  logic signed [ssra_pkg::VAL_W-1:0] op_value,
    input  logic signed [ssra_pkg::VAL_W-1:0] cur_const,
    input  logic [IDX_W-1:0]                  in_index,
    input  logic signed [ssra_pkg::VAL_W-1:0] in_value,
    output logic [IDX_W-1:0]                  ret_index,
    output logic signed [ssra_pkg::VAL_W-1:0] ret_value,
    output ssra_pkg::head_stat_t              stat
);

    // Control registers
    logic            done_reg,     done_next;
    logic            shifting_reg, shifting_next;
    logic            inserted_reg, inserted_next;
    logic            overflow_reg, overflow_next;
    logic            sat_reg,      sat_next;
    ssra_pkg::mode_t a_mode_reg,   a_mode_next;

    // Payload registers
    logic [IDX_W-1:0]                    carry_idx_reg, carry_idx_next;
    logic signed [ssra_pkg::VAL_W-1:0]   carry_val_reg, carry_val_next;
    logic [IDX_W-1:0]                    a_idx_reg,     a_idx_next;
    logic signed [ssra_pkg::VAL_W-1:0]   a_val_reg,     a_val_next;
    logic signed [2*ssra_pkg::VAL_W-1:0] a_prod_reg,    a_prod_next;

    logic signed [ssra_pkg::VAL_W-1:0]   mul_a;
    ssra_pkg::qres_t                     acc_res;
    ssra_pkg::qres_t                     scl_res;
    logic                                ret_clip;

    // Multiplicand: the entry, or the constant term in the spare slot
    assign mul_a = ctrl.const_slot ? cur_const : in_value;

    // Decision and stage A loading
    always_comb
    begin
        done_next      = done_reg;
        shifting_next  = shifting_reg;
        inserted_next  = inserted_reg;
        overflow_next  = overflow_reg;
        sat_next       = sat_reg;
        a_mode_next    = a_mode_reg;
        carry_idx_next = carry_idx_reg;
        carry_val_next = carry_val_reg;
        a_idx_next     = a_idx_reg;
        a_val_next     = a_val_reg;
        a_prod_next    = a_prod_reg;
        if (ctrl.start)
        begin
            done_next     = 1'b0;
            shifting_next = 1'b0;
            inserted_next = 1'b0;
            overflow_next = 1'b0;
            sat_next      = 1'b0;
            a_mode_next   = ssra_pkg::MODE_PASS;
        end
        else if (ctrl.shift)
        begin
            a_idx_next  = in_index;
            a_val_next  = in_value;
            a_mode_next = ssra_pkg::MODE_PASS;
            a_prod_next = mul_a * op_value;
            sat_next    = sat_reg | ret_clip;
            if (shifting_reg)
            begin
                // Entries after the insert point move up one place
                a_idx_next     = carry_idx_reg;
                a_val_next     = carry_val_reg;
                carry_idx_next = in_index;
                carry_val_next = in_value;
            end
            else if (ctrl.add_coef && !done_reg)
            begin
                if (ctrl.const_slot)
                begin
                    // Larger than every entry of a full table
                    overflow_next = 1'b1;
                    done_next     = 1'b1;
                end
                else if (ctrl.occupied && (op_index == in_index))
                begin
                    a_mode_next = ssra_pkg::MODE_ACC;
                    done_next   = 1'b1;
                end
                else if (!ctrl.occupied || (op_index < in_index))
                begin
                    done_next = 1'b1;
                    if (ctrl.table_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        a_idx_next     = op_index;
                        a_val_next     = op_value;
                        carry_idx_next = in_index;
                        carry_val_next = in_value;
                        shifting_next  = 1'b1;
                        inserted_next  = 1'b1;
                    end
                end
            end
            else if (ctrl.scale && (ctrl.occupied || ctrl.const_slot))
            begin
                a_mode_next = ssra_pkg::MODE_SCALE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            shifting_reg <= 1'b0;
            inserted_reg <= 1'b0;
            overflow_reg <= 1'b0;
            sat_reg      <= 1'b0;
            a_mode_reg   <= ssra_pkg::MODE_PASS;
        end
        else
        begin
            done_reg     <= done_next;
            shifting_reg <= shifting_next;
            inserted_reg <= inserted_next;
            overflow_reg <= overflow_next;
            sat_reg      <= sat_next;
            a_mode_reg   <= a_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_idx_reg <= carry_idx_next;
        carry_val_reg <= carry_val_next;
        a_idx_reg     <= a_idx_next;
        a_val_reg     <= a_val_next;
        a_prod_reg    <= a_prod_next;
    end

    // Stage A result: saturating add, rounded product, or the entry passed through
    assign acc_res = ssra_pkg::q_sat_add(a_val_reg, op_value);
    assign scl_res = ssra_pkg::q_round_clip(a_prod_reg);

    always_comb
    begin
        ret_value = a_val_reg;
        ret_clip  = 1'b0;
        case (a_mode_reg)
            ssra_pkg::MODE_ACC:
            begin
                ret_value = acc_res.value;
                ret_clip  = acc_res.clipped;
            end
            ssra_pkg::MODE_SCALE:
            begin
                ret_value = scl_res.value;
                ret_clip  = scl_res.clipped;
            end
            default:
            begin
                ret_value = a_val_reg;
                ret_clip  = 1'b0;
            end
        endcase
    end

    assign ret_index     = a_idx_reg;
    assign stat.inserted = inserted_reg;
    assign stat.overflow = overflow_reg;
    assign stat.sat_seen = sat_reg;
    assign stat.ret_clip = ret_clip;

endmodule
